// ===== hw/rtl/json_string_unescape_core_assert.svh =====
// Assertion macros shared by the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds on every clock outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds on any clock outside reset.
`define JSU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/jsu_pkg.sv =====
// Types, constants and helper functions of the JSON string unescape core.
package jsu_pkg;

	localparam int NUM_SLOTS = 4;
	localparam int SLOT_CW   = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_IW   = $clog2(NUM_SLOTS);
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = $clog2(Q_DEPTH);
	localparam int Q_CW      = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] CAP_RESET = 16'd128;
	localparam logic [15:0] POS_MAX   = 16'hFFFF;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] BYTE_BS   = 8'h08;
	localparam logic [7:0] BYTE_FF   = 8'h0C;
	localparam logic [7:0] BYTE_LF   = 8'h0A;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] BYTE_TAB  = 8'h09;

	// UTF-8 range limits and lead/continuation marks
	localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
	localparam logic [15:0] CP_2B_LIMIT = 16'h0800;
	localparam logic [2:0]  LEAD2_MARK  = 3'b110;
	localparam logic [3:0]  LEAD3_MARK  = 4'b1110;
	localparam logic [1:0]  CONT_MARK   = 2'b10;
	localparam logic [2:0]  HEX_FULL    = 3'd4;

	typedef enum logic [1:0] {
		K_DATA  = 2'd0,
		K_DONE  = 2'd1,
		K_NOQ   = 2'd2,
		K_UNTRM = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       kept;
	} slot_t;

	// All results caused by one input character
	typedef struct packed {
		logic [SLOT_CW-1:0]          cnt;
		logic [15:0]                 length;
		slot_t [NUM_SLOTS-1:0]       slot;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
	} utf8_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	// Decode one hex digit character.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		logic [7:0] t;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			r.valid = 1'b1;
			r.value = t[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			r.valid = 1'b1;
			r.value = t[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			r.valid = 1'b1;
			r.value = t[3:0];
		end
		return r;
	endfunction

	// Encode a 16-bit code point as 1 to 3 UTF-8 bytes, first byte in slot 0.
	function automatic utf8_t utf8_encode(input logic [15:0] cp);
		utf8_t r;
		r = '0;
		if (cp < CP_1B_LIMIT) begin
			r.cnt = 2'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp < CP_2B_LIMIT) begin
			r.cnt = 2'd2;
			r.bytes[0] = {LEAD2_MARK, cp[10:6]};
			r.bytes[1] = {CONT_MARK, cp[5:0]};
		end else begin
			r.cnt = 2'd3;
			r.bytes[0] = {LEAD3_MARK, cp[15:12]};
			r.bytes[1] = {CONT_MARK, cp[11:6]};
			r.bytes[2] = {CONT_MARK, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/jsu_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
interface jsu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface jsu_res_if;
	logic           valid;
	logic           ready;
	jsu_pkg::kind_t kind;
	logic [7:0]     data;
	logic           kept;
	logic [15:0]    length;
	logic           last;
	modport source(output valid, output kind, output data, output kept, output length,
		output last, input ready);
	modport sink(input valid, input kind, input data, input kept, input length,
		input last, output ready);
endinterface

// ===== hw/rtl/json_string_unescape_core.sv =====
// Top level of the JSON string unescape core.
//
// char_in carries one character per beat (value 0 is end of text); res_out carries one
// decoded result per beat: a data byte with its kept flag, a done marker with the decoded
// length, or an error. The last flag marks the final result of one input character.
// cfg_we/cfg_wdata write the output capacity (reset value 128); write only while idle.
// Results of a character pass through the bundle queue and then the output register.
// Throughput: one character per cycle while each character yields at most one result
// and the receiver is ready. A short unicode escape can yield up to four results; the
// output side then sends one per cycle while the receiver is ready, and a four-entry
// bundle queue between decoder and output absorbs bursts. char_in.ready drops only
// when that queue is full. When the receiver stalls, the output register holds its
// beat and the queue fills; decoding continues until the queue is full.
// Reset clears the decoder to wait for an opening quote, empties the queue and the
// output register, and restores the capacity to 128.
module json_string_unescape_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	jsu_char_if.sink    char_in,
	jsu_res_if.source   res_out
);
	import jsu_pkg::*;

	logic     push;
	bundle_t  push_data;
	logic     pop;
	bundle_t  head;
	q_stat_t  q_stat;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.char_in   (char_in),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.res_out (res_out)
	);

endmodule

// ===== hw/rtl/jsu_front.sv =====
// Front end: accepts characters, runs the string decoder and builds result bundles.
`include "json_string_unescape_core_assert.svh"
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	jsu_char_if.sink          char_in,
	input  jsu_pkg::q_stat_t  q_stat,
	output logic              push,
	output jsu_pkg::bundle_t  push_data
);
	import jsu_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_BODY = 4'b0010,
		PH_ESC  = 4'b0100,
		PH_HEX  = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hex_q, hex_d;
	logic [15:0] cp_q, cp_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] cap_q;

	logic        accept;
	logic        u_en;
	logic [15:0] u_cp;
	utf8_t       u_enc;
	logic [2:0]  u_n;
	logic        u_kept;
	logic [16:0] sum1;
	logic [15:0] pos1;
	logic        body_en;
	logic        t_en;
	kind_t       t_kind;
	logic [7:0]  t_data;
	logic        t_kept;
	logic [16:0] sum2;
	hex_t        hv;
	logic [15:0] cp_new;
	logic [2:0]  hex_new;
	logic [NUM_SLOTS-1:0][7:0] u_bytes;

	assign char_in.ready = !q_stat.full;
	assign accept = char_in.valid && char_in.ready;

	// Classify the character and pick the UTF-8 group and trailing result
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		cp_d    = cp_q;
		u_en    = 1'b0;
		u_cp    = cp_q;
		body_en = 1'b0;
		t_en    = 1'b0;
		t_kind  = K_DATA;
		t_data  = '0;
		hv      = hex_decode(char_in.ch);
		cp_new  = {cp_q[11:0], hv.value};
		hex_new = hex_q + 3'd1;
		unique case (phase_q)
			PH_IDLE: begin
				if (char_in.ch == CH_QUOTE) begin
					phase_d = PH_BODY;
				end else begin
					t_en   = 1'b1;
					t_kind = K_NOQ;
				end
			end
			PH_BODY: begin
				body_en = 1'b1;
			end
			PH_ESC: begin
				phase_d = PH_BODY;
				t_en    = 1'b1;
				unique case (char_in.ch)
					CH_NUL: begin
						phase_d = PH_IDLE;
						t_kind  = K_UNTRM;
					end
					CH_LOW_U: begin
						phase_d = PH_HEX;
						hex_d   = '0;
						cp_d    = '0;
						t_en    = 1'b0;
					end
					CH_LOW_B: t_data = BYTE_BS;
					CH_LOW_F: t_data = BYTE_FF;
					CH_LOW_N: t_data = BYTE_LF;
					CH_LOW_R: t_data = BYTE_CR;
					CH_LOW_T: t_data = BYTE_TAB;
					default:  t_data = char_in.ch;
				endcase
			end
			PH_HEX: begin
				u_en    = 1'b1;
				phase_d = PH_BODY;
				if (hv.valid) begin
					cp_d  = cp_new;
					hex_d = hex_new;
					u_cp  = cp_new;
					if (hex_new < HEX_FULL) begin
						u_en    = 1'b0;
						phase_d = PH_HEX;
					end
				end else begin
					body_en = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// Handle a plain string body character
		if (body_en) begin
			t_en = 1'b1;
			if (char_in.ch == CH_NUL) begin
				phase_d = PH_IDLE;
				t_kind  = K_UNTRM;
			end else if (char_in.ch == CH_QUOTE) begin
				phase_d = PH_IDLE;
				t_kind  = K_DONE;
			end else if (char_in.ch == CH_BSLASH) begin
				phase_d = PH_ESC;
				t_en    = 1'b0;
			end else begin
				t_data = char_in.ch;
			end
		end
	end

	// Place bytes against the output position and capacity
	always_comb begin
		u_enc  = utf8_encode(u_cp);
		u_n    = u_en ? {1'b0, u_enc.cnt} : 3'd0;
		u_kept = ({1'b0, pos_q} + 17'(u_enc.cnt)) < {1'b0, cap_q};
		sum1   = {1'b0, pos_q} + 17'(u_n);
		pos1   = sum1[16] ? POS_MAX : sum1[15:0];
		t_kept = (t_kind == K_DATA) && (({1'b0, pos1} + 17'd1) < {1'b0, cap_q});
		sum2   = {1'b0, pos1} + 17'((t_en && t_kind == K_DATA) ? 1 : 0);
		if (phase_q == PH_IDLE) begin
			pos_d = '0;
		end else begin
			pos_d = sum2[16] ? POS_MAX : sum2[15:0];
		end
		u_bytes = '0;
		u_bytes[2:0] = u_enc.bytes;
	end

	// Assemble the bundle: UTF-8 bytes first, then the trailing result
	always_comb begin
		push_data        = '0;
		push_data.cnt    = SLOT_CW'(u_n) + SLOT_CW'(t_en);
		push_data.length = (t_kind == K_DONE) ? pos1 : 16'd0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (3'(i) < u_n) begin
				push_data.slot[i].kind = K_DATA;
				push_data.slot[i].data = u_bytes[i];
				push_data.slot[i].kept = u_kept;
			end else if (t_en && 3'(i) == u_n) begin
				push_data.slot[i].kind = t_kind;
				push_data.slot[i].data = t_data;
				push_data.slot[i].kept = t_kept;
			end
		end
	end

	assign push = accept && (push_data.cnt != '0);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Advance decoder state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
			cp_q    <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			cp_q    <= cp_d;
			pos_q   <= pos_d;
		end
	end

	`JSU_ASSERT(a_hex_count, (phase_q == PH_HEX) |-> (hex_q < HEX_FULL), "hex digit count overrun")
	`JSU_NEVER(a_push_cnt, push && (push_data.cnt > SLOT_CW'(NUM_SLOTS)), "bundle overflows slots")

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// Short bundle queue between the decoder front end and the output back end.
`include "json_string_unescape_core_assert.svh"
module jsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::bundle_t  push_data,
	input  logic              pop,
	output jsu_pkg::bundle_t  head,
	output jsu_pkg::q_stat_t  q_stat
);
	import jsu_pkg::*;

	bundle_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [Q_CW-1:0]     count_q;

	assign q_stat.full  = (count_q == Q_CW'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Store a bundle at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + Q_CW'(push) - Q_CW'(pop);
		end
	end

	`JSU_NEVER(a_push_full, push && q_stat.full, "push into full queue")
	`JSU_NEVER(a_pop_empty, pop && q_stat.empty, "pop from empty queue")

endmodule

// ===== hw/rtl/jsu_back.sv =====
// Back end: unpacks queued bundles into single result beats behind an output register.
`include "json_string_unescape_core_assert.svh"
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::bundle_t  head,
	input  jsu_pkg::q_stat_t  q_stat,
	output logic              pop,
	jsu_res_if.source         res_out
);
	import jsu_pkg::*;

	logic                 valid_q;
	logic [SLOT_IW-1:0]   idx_q;
	kind_t                kind_q;
	logic [7:0]           data_q;
	logic                 kept_q;
	logic [15:0]          length_q;
	logic                 last_q;

	logic                 load;
	logic                 sel_last;
	slot_t                sel;

	assign load     = !q_stat.empty && (!valid_q || res_out.ready);
	assign sel      = head.slot[idx_q];
	assign sel_last = (SLOT_CW'(idx_q) + SLOT_CW'(1)) == head.cnt;
	assign pop      = load && sel_last;

	// Track output valid and the slot being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= sel_last ? '0 : idx_q + SLOT_IW'(1);
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= sel.kind;
			data_q   <= sel.data;
			kept_q   <= sel.kept;
			length_q <= (sel.kind == K_DONE) ? head.length : 16'd0;
			last_q   <= sel_last;
		end
	end

	assign res_out.valid  = valid_q;
	assign res_out.kind   = kind_q;
	assign res_out.data   = data_q;
	assign res_out.kept   = kept_q;
	assign res_out.length = length_q;
	assign res_out.last   = last_q;

	`JSU_ASSERT(a_idx_range, !q_stat.empty |-> (SLOT_CW'(idx_q) < head.cnt), "slot index past bundle")

endmodule
